// ===== rtl/xtbg_pkg.sv =====
// Shared constants, types and the reset word table of the XOR table byte generator.
`default_nettype none

package xtbg_pkg;

    localparam int TBL_DEPTH   = 64;
    localparam int ADDR_W      = $clog2(TBL_DEPTH);
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int BYTE_LSB    = 16;
    localparam int SPREAD_DIST = 4;
    localparam int NUM_DIG     = 4;
    localparam int CNT_W       = ADDR_W + 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Transaction opcodes
    localparam logic OP_GEN    = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Table contents after reset
    localparam t_word INIT_WORDS [TBL_DEPTH] = '{
        32'h7be9c1bd, 32'h88aa1020, 32'h3d38509b, 32'h746b9fbe,
        32'h2d04417f, 32'h775d4351, 32'h53c48d96, 32'hc2b26e0b,
        32'h418fedcf, 32'h19dbc19e, 32'h78512adb, 32'h1a1f5e2b,
        32'hb07d7761, 32'h6584c1f0, 32'h24e3c36f, 32'h2232310f,
        32'h2dac5ceb, 32'h106e8b5a, 32'h5a05a938, 32'h5e6392b6,
        32'h66b90348, 32'h75264901, 32'h4174f402, 32'hd18b18a4,
        32'h3a6ab4bf, 32'h3c4bc289, 32'h2657a9a9, 32'h4e68589b,
        32'h89648aa6, 32'h3fc489bb, 32'h1c1b715c, 32'h054e4c63,
        32'h484f2abd, 32'h5953c1f8, 32'h79b9ec22, 32'h75536c3d,
        32'h50b10549, 32'h4d7e79b8, 32'h7805da48, 32'h1240f318,
        32'h675a3b56, 32'h70570523, 32'h2c605143, 32'h17d7b2b7,
        32'h55dbc713, 32'h514414b2, 32'h3a09e3c7, 32'ha38823ff,
        32'h61b2a00c, 32'h140f8cff, 32'h61ebb6b5, 32'h486ba354,
        32'h0935d600, 32'h2360aab8, 32'h29f6bbf8, 32'h43a08abf,
        32'h5fac6d41, 32'h504e65a2, 32'hb208e35b, 32'h6910f7e7,
        32'h1012ef5d, 32'h2e2454b7, 32'h6e5f444b, 32'h58621a1b
    };

    // Table access request from the sequencer
    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr_a;
        t_addr rd_addr_b;
        logic  wr_en;
        t_addr wr_addr;
        t_word wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/xtbg_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface xtbg_in_if;
    import xtbg_pkg::*;

    logic        valid;
    logic        ready;
    logic        op;
    t_word       digest_word0;
    t_word       digest_word1;
    t_word       digest_word2;
    t_word       digest_word3;

    modport source (
        output valid, op, digest_word0, digest_word1, digest_word2, digest_word3,
        input  ready
    );
    modport sink (
        input  valid, op, digest_word0, digest_word1, digest_word2, digest_word3,
        output ready
    );
endinterface

interface xtbg_out_if;
    import xtbg_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] random_byte;

    modport source (output valid, random_byte, input ready);
    modport sink   (input valid, random_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/xtbg_mem.sv =====
// Word table: one write port, two registered read ports, reset contents via valid bits.
`default_nettype none

module xtbg_mem (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  xtbg_pkg::t_mem_req i_req,
    output xtbg_pkg::t_word    o_rd_a,
    output xtbg_pkg::t_word    o_rd_b
);
    import xtbg_pkg::*;

    t_word                r_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_valid;
    t_word                r_raw_a;
    t_word                r_raw_b;
    logic                 r_va;
    logic                 r_vb;
    t_addr                r_ia;
    t_addr                r_ib;

    // Storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_raw_a <= r_mem[i_req.rd_addr_a];
            r_raw_b <= r_mem[i_req.rd_addr_b];
            r_va    <= r_valid[i_req.rd_addr_a];
            r_vb    <= r_valid[i_req.rd_addr_b];
            r_ia    <= i_req.rd_addr_a;
            r_ib    <= i_req.rd_addr_b;
        end
    end

    // Written flags: an unwritten entry still holds its reset word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_a = r_va ? r_raw_a : INIT_WORDS[r_ia];
    assign o_rd_b = r_vb ? r_raw_b : INIT_WORDS[r_ib];

endmodule

`default_nettype wire

// ===== rtl/xor_table_byte_generator.sv =====
// Generate: the accept cycle issues the table read; the byte enters the output register once it is free.
// Reseed: no result (accept cycle, 4 XOR read-modify-writes, OR sweep, zero-column fix,
// pipelined spread); the table has a single write port.
// A new item is taken while a byte still waits in the output register.
// Synchronous active-low reset: pointer to 0, sequencer idle, table back to its constants.
`default_nettype none

module xor_table_byte_generator (
    input  wire  i_clk,
    input  wire  i_rst_n,
    xtbg_in_if.sink    i_in,
    xtbg_out_if.source o_out
);
    import xtbg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GEN    = 3'd1;
    localparam logic [2:0] S_MIX_RD = 3'd2;
    localparam logic [2:0] S_MIX_WR = 3'd3;
    localparam logic [2:0] S_OR     = 3'd4;
    localparam logic [2:0] S_FIX    = 3'd5;
    localparam logic [2:0] S_SPREAD = 3'd6;

    localparam t_cnt CNT_END = CNT_W'(TBL_DEPTH);
    localparam t_cnt CNT_MIX = CNT_W'(NUM_DIG - 1);

    logic [2:0]        r_state,     n_state;
    t_addr             r_ptr,       n_ptr;
    t_cnt              r_cnt,       n_cnt;
    logic              r_pend,      n_pend;
    t_addr             r_pend_addr, n_pend_addr;
    t_word             r_or,        n_or;
    t_word             r_e0,        n_e0;
    t_word             r_dig [NUM_DIG];
    t_word             n_dig [NUM_DIG];
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;

    t_mem_req mem_req;
    t_word    rd_a;
    t_word    rd_b;
    logic     in_acc;
    logic     out_free;
    t_addr    spread_addr;

    xtbg_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign in_acc            = i_in.valid & i_in.ready;
    assign out_free          = ~r_out_valid | o_out.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.random_byte = r_out_byte;
    assign spread_addr       = r_ptr - r_cnt[ADDR_W-1:0];

    // Sequencer: read, modify and write back the table
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_or        = r_or;
        n_e0        = r_e0;
        n_dig       = r_dig;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_byte  = r_out_byte;
        mem_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == OP_RESEED) begin
                        n_dig[0] = i_in.digest_word0;
                        n_dig[1] = i_in.digest_word1;
                        n_dig[2] = i_in.digest_word2;
                        n_dig[3] = i_in.digest_word3;
                        n_cnt    = '0;
                        n_state  = S_MIX_RD;
                    end else begin
                        mem_req.rd_en     = 1'b1;
                        mem_req.rd_addr_a = r_ptr;
                        mem_req.rd_addr_b = r_ptr + ADDR_W'(1);
                        n_state           = S_GEN;
                    end
                end
            end

            // Emit the byte and fold the word into the entry above
            S_GEN: begin
                if (out_free) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_ptr + ADDR_W'(1);
                    mem_req.wr_data = rd_b ^ rd_a;
                    n_out_valid     = 1'b1;
                    n_out_byte      = rd_a[BYTE_LSB +: BYTE_W];
                    n_ptr           = r_ptr - ADDR_W'(1);
                    n_state         = S_IDLE;
                end
            end

            S_MIX_RD: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = r_ptr;
                mem_req.rd_addr_b = r_ptr;
                n_state           = S_MIX_WR;
            end

            // XOR one digest word in, pointer steps down
            S_MIX_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_ptr;
                mem_req.wr_data = rd_a ^ r_dig[r_cnt[1:0]];
                n_ptr           = r_ptr - ADDR_W'(1);
                if (r_cnt == CNT_MIX) begin
                    n_cnt   = '0;
                    n_or    = '0;
                    n_state = S_OR;
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_MIX_RD;
                end
            end

            // OR sweep over the whole table, keeping entry 0 aside
            S_OR: begin
                if (r_cnt != CNT_END) begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = r_cnt[ADDR_W-1:0];
                    mem_req.rd_addr_b = r_cnt[ADDR_W-1:0];
                    n_pend            = 1'b1;
                    n_pend_addr       = r_cnt[ADDR_W-1:0];
                    n_cnt             = r_cnt + CNT_W'(1);
                end
                if (r_pend) begin
                    n_or = r_or | rd_a;
                    if (r_pend_addr == '0) begin
                        n_e0 = rd_a;
                    end
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_FIX;
                end
            end

            // Bit columns that are zero everywhere become ones in entry 0
            S_FIX: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = r_e0 | ~r_or;
                n_cnt           = '0;
                n_state         = S_SPREAD;
            end

            // Pipelined spread: read j and j+4, write j in the next cycle
            S_SPREAD: begin
                if (r_cnt != CNT_END) begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = spread_addr;
                    mem_req.rd_addr_b = spread_addr + ADDR_W'(SPREAD_DIST);
                    n_pend            = 1'b1;
                    n_pend_addr       = spread_addr;
                    n_cnt             = r_cnt + CNT_W'(1);
                end
                if (r_pend) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pend_addr;
                    mem_req.wr_data = rd_a ^ rd_b;
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_or        <= n_or;
        r_e0        <= n_e0;
        r_dig       <= n_dig;
        r_out_byte  <= n_out_byte;
    end

    // A new byte only ever comes from the generate write-back
    a_byte_from_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_GEN))
        else $error("output byte loaded outside generate");

    // Pointer moves only on generate or digest mixing
    a_ptr_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_ptr) |-> ($past(r_state == S_GEN) || $past(r_state == S_MIX_WR)))
        else $error("read pointer moved in wrong state");

    // Sweep counter never runs past the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OR || r_state == S_SPREAD) |-> (r_cnt <= CNT_END))
        else $error("sweep counter overran");

    // Table writes only in the write-back states
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (r_state == S_GEN || r_state == S_MIX_WR
                           || r_state == S_FIX || r_state == S_SPREAD))
        else $error("table written in wrong state");

endmodule

`default_nettype wire

// ===== tb/xor_table_byte_generator_tb.sv =====
// Self-checking testbench for the XOR table byte generator: predicted byte stream, random stalls.
`timescale 1ns / 1ps

import xtbg_pkg::*;

// Mirror of the word table and pointer, with the bytes still owed by the block
class xtbg_byte_scoreboard;
    t_word             word_table [TBL_DEPTH];
    t_addr             read_ptr;
    logic [BYTE_W-1:0] pending_bytes [$];
    int unsigned       mismatches;

    function new();
        foreach (word_table[k]) word_table[k] = INIT_WORDS[k];
        read_ptr   = '0;
        mismatches = 0;
    endfunction

    // Update the table for one accepted input transaction
    function void note_transaction(input logic op, input t_word d0, input t_word d1,
                                   input t_word d2, input t_word d3);
        t_word digest [NUM_DIG];
        t_word col_or;
        t_word w;
        t_addr idx;
        if (op == OP_RESEED) begin
            digest = '{d0, d1, d2, d3};
            for (int n = 0; n < NUM_DIG; n++) begin
                word_table[read_ptr] ^= digest[n];
                read_ptr = read_ptr - 1'b1;
            end
            // any bit column that is zero everywhere is set in entry 0
            col_or = '0;
            foreach (word_table[k]) col_or |= word_table[k];
            word_table[0] |= ~col_or;
            // spread downwards from the pointer, each entry takes in the one four above
            idx = read_ptr;
            repeat (TBL_DEPTH) begin
                word_table[idx] ^= word_table[t_addr'(idx + SPREAD_DIST)];
                idx = idx - 1'b1;
            end
        end else begin
            w = word_table[read_ptr];
            word_table[t_addr'(read_ptr + 1'b1)] ^= w;
            read_ptr = read_ptr - 1'b1;
            pending_bytes.push_back(w[BYTE_LSB +: BYTE_W]);
        end
    endfunction

    // Compare one accepted result with the oldest owed byte
    function void check_byte(input logic [BYTE_W-1:0] actual);
        logic [BYTE_W-1:0] want;
        if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected random_byte, expected none, actual %h", $time, actual);
            mismatches++;
        end else begin
            want = pending_bytes.pop_front();
            if (want !== actual) begin
                $display("%0t: random_byte expected %h, actual %h", $time, want, actual);
                mismatches++;
            end
        end
    endfunction
endclass

module xor_table_byte_generator_tb;

    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 160;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RAND_BLOCKS     = 8;
    localparam int RAND_PER_BLOCK  = 104;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xtbg_in_if  in_if ();
    xtbg_out_if out_if ();

    xor_table_byte_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    xtbg_byte_scoreboard sb = new();

    bit          sender_gaps;
    bit          hold_off_req;
    int unsigned idle_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Digest word with a bias towards the extremes
    function automatic t_word pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else
            return $urandom;
    endfunction

    // Offer one transaction and return at the edge that accepts it
    task automatic send_item(input logic op, input t_word d0, input t_word d1,
                             input t_word d2, input t_word d3);
        int unsigned gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.digest_word0 <= d0;
        in_if.digest_word1 <= d1;
        in_if.digest_word2 <= d2;
        in_if.digest_word3 <= d3;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Stop offering until every owed byte has come out
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, steady stretches and one requested long hold-off
    initial begin
        int unsigned n;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(50, 150)) @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Monitor both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_byte(out_if.random_byte);
            if (in_if.valid && in_if.ready)
                sb.note_transaction(in_if.op, in_if.digest_word0, in_if.digest_word1,
                                    in_if.digest_word2, in_if.digest_word3);
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        t_addr p;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_GEN;
        in_if.digest_word0 <= '0;
        in_if.digest_word1 <= '0;
        in_if.digest_word2 <= '0;
        in_if.digest_word3 <= '0;
        sender_gaps  = 1'b0;
        hold_off_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes straight from the reset table, pointer wraps from 0 to 63
        repeat (4) send_item(OP_GEN, '0, '0, '0, '0);
        // digest words are ignored on generate
        send_item(OP_GEN, '1, '1, '1, '1);
        // reseed with extreme and patterned digests
        send_item(OP_RESEED, '0, '0, '0, '0);
        repeat (2) send_item(OP_GEN, '0, '0, '0, '0);
        send_item(OP_RESEED, '1, '1, '1, '1);
        send_item(OP_GEN, 32'h5555_5555, '0, '1, 32'haaaa_aaaa);
        send_item(OP_RESEED, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        repeat (2) send_item(OP_GEN, '0, '0, '0, '0);

        // reseed that zeroes the four entries it touches before repair and spread
        drain_results();
        p = sb.read_ptr;
        send_item(OP_RESEED, sb.word_table[p], sb.word_table[t_addr'(p - 1)],
                  sb.word_table[t_addr'(p - 2)], sb.word_table[t_addr'(p - 3)]);
        repeat (4) send_item(OP_GEN, '0, '0, '0, '0);

        // random part, gaps switched off in every third block
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            sender_gaps = (blk % 3) != 1;
            if (blk == 3) begin
                // keep offering while the result side holds off
                sender_gaps  = 1'b0;
                hold_off_req = 1'b1;
                do
                    send_item(OP_GEN, $urandom, $urandom, $urandom, $urandom);
                while (hold_off_req);
                sender_gaps = 1'b1;
            end
            if (blk == 5)
                drain_results();
            repeat (RAND_PER_BLOCK) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(OP_RESEED, pick_word(), pick_word(), pick_word(), pick_word());
                else
                    send_item(OP_GEN, $urandom, $urandom, $urandom, $urandom);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
